// ----- rtl/rcb_pkg.sv -----
// shared types and codes for the recursive coordinate bisection block
// item structs, action/status/register codes, sequencer states, default sizes
`default_nettype none

package rcb_pkg;

    localparam int MAX_POINTS_DEF    = 1024;
    localparam int MAX_GRID_SIDE_DEF = 256;
    localparam int STACK_DEPTH_DEF   = 32;

    localparam int SIDE_CFG_W = 9;
    localparam int TOL_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CELL_W     = 16;
    localparam int COUNT_W    = 11;
    localparam int INDEX_W    = 10;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_RUN    = 2'd2,
        ACT_READ   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STS_OK   = 2'd0,
        STS_FULL = 2'd1,
        STS_BAD  = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COLUMNS   = 2'd0,
        REG_ROWS      = 2'd1,
        REG_TOLERANCE = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] x_coord;
        logic signed [31:0] y_coord;
        logic [INDEX_W-1:0] point_index;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [CELL_W-1:0]  partition;
        logic [COUNT_W-1:0] point_count;
    } out_item_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RESP,
        S_INIT,
        S_POP,
        S_MUL,
        S_DIV,
        S_KEY_RD,
        S_KEY_WAIT,
        S_KEY_PT,
        S_PRED_RD,
        S_PRED_WAIT,
        S_PRED_CMP,
        S_PUSH_HI,
        S_PUSH_LO,
        S_LEAF_RD,
        S_LEAF_WR
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/recursive_coordinate_bisection.sv -----
// recursive coordinate bisection of 2d points onto a columns x rows grid
// single module: sequencer around point, order and cell memories; uses rcb_pkg
//
// usage: items enter on in_valid/in_stall, one result item leaves per input item
// on out_valid/out_stall. grid_columns, grid_rows and tolerance are written on
// the cfg channel (cfg_ready is always high), by the user only while the block
// is idle; the block itself does not enforce this. clear, append and read
// items pass an accept step and then a response step in which the output
// register loads once the output is free; read data comes from the registered
// read port of the cell memory. in_stall is high from accept until the result
// is in the output register, so one item is at work at a time. a run item seeds
// the order and cell memories, then per segment does a multiply, a bit-serial
// divide for the split point and an insertion sort, all through the single read
// port of the order and point memories; leaves then write each point's cell.
// reset clears the point count, the partitioned flag and the registers to
// 1, 1, 1; the memories are not cleared. a stalled result holds in the output
// register and the block waits in its response step until it is taken.
`default_nettype none

module recursive_coordinate_bisection
    import rcb_pkg::*;
#(
    parameter int MAX_POINTS    = MAX_POINTS_DEF,
    parameter int MAX_GRID_SIDE = MAX_GRID_SIDE_DEF,
    parameter int STACK_DEPTH   = STACK_DEPTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_item_t              in_item,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_item_t                  out_item,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW  = $clog2(MAX_POINTS);
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int GW  = $clog2(MAX_GRID_SIDE + 1);
    localparam int NW  = GW + CW;
    localparam int BW  = $clog2(NW + 1);
    localparam int SIW = $clog2(STACK_DEPTH);
    localparam int SW  = $clog2(STACK_DEPTH + 1);

    typedef struct packed {
        logic [CW-1:0] start;
        logic [CW-1:0] count;
        logic [GW-1:0] px;
        logic [GW-1:0] py;
        logic [GW-1:0] dx;
        logic [GW-1:0] dy;
    } seg_t;

    function automatic logic tol_gt(input logic signed [31:0] a,
                                    input logic signed [31:0] b,
                                    input logic [TOL_W-1:0] t);
        logic signed [33:0] ae;
        logic signed [33:0] be;
        ae = 34'(a);
        be = 34'(b) + $signed({18'd0, t});
        return ae > be;
    endfunction

    function automatic logic [GW-1:0] clamp_side(input logic [SIDE_CFG_W-1:0] v);
        if (v == '0)
            return GW'(1);
        else if (32'(v) > 32'(MAX_GRID_SIDE))
            return GW'(MAX_GRID_SIDE);
        else
            return GW'(v);
    endfunction

    // memories
    logic [63:0]       pt_mem [MAX_POINTS];
    logic [AW-1:0]     ord_mem [MAX_POINTS];
    logic [CELL_W-1:0] cell_mem [MAX_POINTS];
    seg_t              stack_mem [STACK_DEPTH];

    logic [63:0]       pt_rd_reg;
    logic [AW-1:0]     ord_rd_reg;
    logic [CELL_W-1:0] cell_rd_reg;

    // registers
    state_t              state_reg, state_next;
    logic [CW-1:0]       loaded_reg, loaded_next;
    logic                flag_reg, flag_next;
    logic [SIDE_CFG_W-1:0] cols_reg, rows_reg;
    logic [TOL_W-1:0]    tol_reg;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_reg, out_next;
    logic [1:0]          sts_reg, sts_next;
    logic                rd_act_reg, rd_act_next;
    logic                rd_ok_reg, rd_ok_next;
    logic [CW-1:0]       i_reg, i_next;
    logic [CW-1:0]       j_reg, j_next;
    logic [SW-1:0]       top_reg, top_next;
    seg_t                g_reg, g_next;
    logic                xsplit_reg, xsplit_next;
    logic [NW-1:0]       num_reg, num_next;
    logic [GW:0]         rem_reg, rem_next;
    logic [BW-1:0]       bit_reg, bit_next;
    logic [CW-1:0]       n0_reg, n0_next;
    logic [CELL_W-1:0]   cell_reg, cell_next;
    logic [AW-1:0]       key_reg, key_next;
    logic signed [31:0]  keyx_reg, keyx_next;
    logic signed [31:0]  keyy_reg, keyy_next;
    logic [AW-1:0]       pred_reg, pred_next;

    // memory controls
    logic              pt_we, pt_re;
    logic [AW-1:0]     pt_wa, pt_ra;
    logic [63:0]       pt_wd;
    logic              ord_we, ord_re;
    logic [AW-1:0]     ord_wa, ord_ra, ord_wd;
    logic              cell_we, cell_re;
    logic [AW-1:0]     cell_wa, cell_ra;
    logic [CELL_W-1:0] cell_wd;
    logic              push_en;
    seg_t              push_seg;

    // combinational helpers
    logic              in_acc;
    logic              out_free;
    logic [GW-1:0]     cols_c, rows_c;
    seg_t              top_seg;
    logic [GW-1:0]     d_sel, p0, p1;
    logic [GW:0]       rem_sh;
    logic              p_gt, p_lt, s_gt, above;
    logic signed [31:0] pred_x, pred_y;
    logic              room;

    assign in_acc    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;
    assign cfg_ready = 1'b1;

    assign cols_c  = clamp_side(cols_reg);
    assign rows_c  = clamp_side(rows_reg);
    assign top_seg = stack_mem[SIW'(top_reg - 1'b1)];
    assign d_sel   = xsplit_reg ? g_reg.dx : g_reg.dy;
    assign p0      = d_sel >> 1;
    assign p1      = d_sel - p0;
    assign rem_sh  = {rem_reg[GW-1:0], num_reg[NW-1]};
    assign room    = (top_reg < SW'(STACK_DEPTH));

    // tolerance compare of the predecessor against the key
    assign pred_x = $signed(pt_rd_reg[31:0]);
    assign pred_y = $signed(pt_rd_reg[63:32]);
    always_comb
    begin
        if (xsplit_reg)
        begin
            p_gt = tol_gt(pred_x, keyx_reg, tol_reg);
            p_lt = tol_gt(keyx_reg, pred_x, tol_reg);
            s_gt = tol_gt(pred_y, keyy_reg, tol_reg);
        end
        else
        begin
            p_gt = tol_gt(pred_y, keyy_reg, tol_reg);
            p_lt = tol_gt(keyy_reg, pred_y, tol_reg);
            s_gt = tol_gt(pred_x, keyx_reg, tol_reg);
        end
        above = p_gt || (!p_lt && s_gt);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                    state_next = (in_item.action == ACT_RUN) ? S_INIT : S_RESP;
            end
            S_RESP:      if (out_free) state_next = S_IDLE;
            S_INIT:      if (i_reg >= loaded_reg) state_next = S_POP;
            S_POP:       state_next = (top_reg == '0) ? S_RESP : S_MUL;
            S_MUL:
            begin
                if (g_reg.dx <= GW'(1) && g_reg.dy <= GW'(1))
                    state_next = S_LEAF_RD;
                else
                    state_next = S_DIV;
            end
            S_DIV:       if (bit_reg == '0) state_next = S_KEY_RD;
            S_KEY_RD:    state_next = (i_reg < g_reg.count) ? S_KEY_WAIT : S_PUSH_HI;
            S_KEY_WAIT:  state_next = S_KEY_PT;
            S_KEY_PT:    state_next = S_PRED_RD;
            S_PRED_RD:   state_next = (j_reg == '0) ? S_KEY_RD : S_PRED_WAIT;
            S_PRED_WAIT: state_next = S_PRED_CMP;
            S_PRED_CMP:  state_next = above ? S_PRED_RD : S_KEY_RD;
            S_PUSH_HI:   state_next = S_PUSH_LO;
            S_PUSH_LO:   state_next = S_POP;
            S_LEAF_RD:   state_next = (i_reg < g_reg.count) ? S_LEAF_WR : S_POP;
            S_LEAF_WR:   state_next = S_LEAF_RD;
            default:     state_next = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        loaded_next    = loaded_reg;
        flag_next      = flag_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        sts_next       = sts_reg;
        rd_act_next    = rd_act_reg;
        rd_ok_next     = rd_ok_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        top_next       = top_reg;
        g_next         = g_reg;
        xsplit_next    = xsplit_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        bit_next       = bit_reg;
        n0_next        = n0_reg;
        cell_next      = cell_reg;
        key_next       = key_reg;
        keyx_next      = keyx_reg;
        keyy_next      = keyy_reg;
        pred_next      = pred_reg;
        pt_we   = 1'b0;
        pt_wa   = AW'(loaded_reg);
        pt_wd   = {in_item.y_coord, in_item.x_coord};
        pt_re   = 1'b0;
        pt_ra   = ord_rd_reg;
        ord_we  = 1'b0;
        ord_wa  = AW'(i_reg);
        ord_wd  = AW'(i_reg);
        ord_re  = 1'b0;
        ord_ra  = AW'(g_reg.start + i_reg);
        cell_we = 1'b0;
        cell_wa = AW'(i_reg);
        cell_wd = '0;
        cell_re = 1'b0;
        cell_ra = AW'(in_item.point_index);
        push_en  = 1'b0;
        push_seg = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    sts_next    = STS_OK;
                    rd_act_next = 1'b0;
                    i_next      = '0;
                    case (in_item.action)
                        ACT_CLEAR:
                        begin
                            loaded_next = '0;
                            flag_next   = 1'b0;
                        end
                        ACT_APPEND:
                        begin
                            if (32'(loaded_reg) >= 32'(MAX_POINTS))
                                sts_next = STS_FULL;
                            else
                            begin
                                pt_we       = 1'b1;
                                loaded_next = loaded_reg + 1'b1;
                                flag_next   = 1'b0;
                            end
                        end
                        ACT_READ:
                        begin
                            rd_act_next = 1'b1;
                            cell_re     = 1'b1;
                            rd_ok_next  = flag_reg &&
                                (32'(in_item.point_index) < 32'(loaded_reg));
                        end
                        default: ;
                    endcase
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next.point_count = COUNT_W'(loaded_reg);
                    if (rd_act_reg && !rd_ok_reg)
                        out_next.status = STS_BAD;
                    else
                        out_next.status = sts_reg;
                    out_next.partition = (rd_act_reg && rd_ok_reg) ? cell_rd_reg : '0;
                end
            end
            S_INIT:
            begin
                if (i_reg < loaded_reg)
                begin
                    ord_we  = 1'b1;
                    cell_we = 1'b1;
                    i_next  = i_reg + 1'b1;
                end
                else
                begin
                    top_next = '0;
                    if (loaded_reg != '0)
                    begin
                        push_en  = 1'b1;
                        push_seg = '{start: '0, count: loaded_reg, px: '0, py: '0,
                                     dx: cols_c, dy: rows_c};
                        top_next = SW'(1);
                    end
                end
            end
            S_POP:
            begin
                if (top_reg == '0)
                    flag_next = 1'b1;
                else
                begin
                    g_next   = top_seg;
                    top_next = top_reg - 1'b1;
                end
            end
            S_MUL:
            begin
                i_next      = '0;
                cell_next   = CELL_W'((2*GW)'(g_reg.py) * (2*GW)'(cols_c) +
                                      (2*GW)'(g_reg.px));
                xsplit_next = (g_reg.dx >= g_reg.dy);
                num_next    = (g_reg.dx >= g_reg.dy) ?
                              NW'(g_reg.dx >> 1) * NW'(g_reg.count) :
                              NW'(g_reg.dy >> 1) * NW'(g_reg.count);
                rem_next    = '0;
                bit_next    = BW'(NW);
            end
            S_DIV:
            begin
                // restoring divide, one quotient bit per cycle
                if (bit_reg != '0)
                begin
                    bit_next = bit_reg - 1'b1;
                    if (rem_sh >= (GW+1)'(d_sel))
                    begin
                        rem_next = rem_sh - (GW+1)'(d_sel);
                        num_next = {num_reg[NW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_sh;
                        num_next = {num_reg[NW-2:0], 1'b0};
                    end
                end
                else
                begin
                    n0_next = CW'(num_reg);
                    i_next  = CW'(1);
                end
            end
            S_KEY_RD:
            begin
                if (i_reg < g_reg.count)
                    ord_re = 1'b1;
            end
            S_KEY_WAIT:
            begin
                key_next = ord_rd_reg;
                pt_re    = 1'b1;
                pt_ra    = ord_rd_reg;
                j_next   = i_reg;
            end
            S_KEY_PT:
            begin
                keyx_next = $signed(pt_rd_reg[31:0]);
                keyy_next = $signed(pt_rd_reg[63:32]);
            end
            S_PRED_RD:
            begin
                if (j_reg == '0)
                begin
                    ord_we = 1'b1;
                    ord_wa = AW'(g_reg.start);
                    ord_wd = key_reg;
                    i_next = i_reg + 1'b1;
                end
                else
                begin
                    ord_re = 1'b1;
                    ord_ra = AW'(g_reg.start + j_reg - 1'b1);
                end
            end
            S_PRED_WAIT:
            begin
                pred_next = ord_rd_reg;
                pt_re     = 1'b1;
                pt_ra     = ord_rd_reg;
            end
            S_PRED_CMP:
            begin
                ord_we = 1'b1;
                ord_wa = AW'(g_reg.start + j_reg);
                if (above)
                begin
                    ord_wd = pred_reg;
                    j_next = j_reg - 1'b1;
                end
                else
                begin
                    ord_wd = key_reg;
                    i_next = i_reg + 1'b1;
                end
            end
            S_PUSH_HI:
            begin
                push_seg.start = g_reg.start + n0_reg;
                push_seg.count = g_reg.count - n0_reg;
                push_seg.px    = xsplit_reg ? g_reg.px + p0 : g_reg.px;
                push_seg.py    = xsplit_reg ? g_reg.py : g_reg.py + p0;
                push_seg.dx    = xsplit_reg ? p1 : g_reg.dx;
                push_seg.dy    = xsplit_reg ? g_reg.dy : p1;
                if (push_seg.count != '0 && room)
                begin
                    push_en  = 1'b1;
                    top_next = top_reg + 1'b1;
                end
            end
            S_PUSH_LO:
            begin
                push_seg.start = g_reg.start;
                push_seg.count = n0_reg;
                push_seg.px    = g_reg.px;
                push_seg.py    = g_reg.py;
                push_seg.dx    = xsplit_reg ? p0 : g_reg.dx;
                push_seg.dy    = xsplit_reg ? g_reg.dy : p0;
                i_next         = '0;
                if (n0_reg != '0 && room)
                begin
                    push_en  = 1'b1;
                    top_next = top_reg + 1'b1;
                end
            end
            S_LEAF_RD:
            begin
                if (i_reg < g_reg.count)
                    ord_re = 1'b1;
            end
            S_LEAF_WR:
            begin
                cell_we = 1'b1;
                cell_wa = ord_rd_reg;
                cell_wd = cell_reg;
                i_next  = i_reg + 1'b1;
            end
            default: ;
        endcase
    end

    // memories: one write and one registered read each; the segment stack has one write and a combinational read
    always_ff @(posedge clk)
    begin
        if (pt_we)
            pt_mem[pt_wa] <= pt_wd;
        if (pt_re)
            pt_rd_reg <= pt_mem[pt_ra];
    end

    always_ff @(posedge clk)
    begin
        if (ord_we)
            ord_mem[ord_wa] <= ord_wd;
        if (ord_re)
            ord_rd_reg <= ord_mem[ord_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cell_we)
            cell_mem[cell_wa] <= cell_wd;
        if (cell_re)
            cell_rd_reg <= cell_mem[cell_ra];
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
            stack_mem[SIW'(top_reg)] <= push_seg;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= SIDE_CFG_W'(1);
            rows_reg <= SIDE_CFG_W'(1);
            tol_reg  <= TOL_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_COLUMNS:   cols_reg <= cfg_data[SIDE_CFG_W-1:0];
                REG_ROWS:      rows_reg <= cfg_data[SIDE_CFG_W-1:0];
                REG_TOLERANCE: tol_reg  <= cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            loaded_reg    <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            top_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            loaded_reg    <= loaded_next;
            flag_reg      <= flag_next;
            out_valid_reg <= out_valid_next;
            top_reg       <= top_next;
        end
    end

    // payload and work registers
    always_ff @(posedge clk)
    begin
        out_reg    <= out_next;
        sts_reg    <= sts_next;
        rd_act_reg <= rd_act_next;
        rd_ok_reg  <= rd_ok_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        g_reg      <= g_next;
        xsplit_reg <= xsplit_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        bit_reg    <= bit_next;
        n0_reg     <= n0_next;
        cell_reg   <= cell_next;
        key_reg    <= key_next;
        keyx_reg   <= keyx_next;
        keyy_reg   <= keyy_next;
        pred_reg   <= pred_next;
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(loaded_reg) <= 32'(MAX_POINTS))
        else $error("point count beyond store size");

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(top_reg) <= 32'(STACK_DEPTH))
        else $error("segment stack overrun");

    a_sort_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PRED_CMP) |-> (j_reg != '0 && j_reg <= i_reg &&
                                       i_reg < g_reg.count))
        else $error("insertion index out of segment");

    a_result_after_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && out_free) |=> (out_valid && state_reg == S_IDLE))
        else $error("response step did not load the output register");

endmodule

`default_nettype wire

// ----- sim/recursive_coordinate_bisection_tb.sv -----
// self-checking testbench for recursive_coordinate_bisection
// directed table, then random point sets under several idle and stall mixes; uses rcb_pkg
`timescale 1ns / 1ps

module recursive_coordinate_bisection_tb;
    import rcb_pkg::*;

    localparam int NPTS  = 1024;
    localparam int NSIDE = 256;
    localparam int NSTK  = 32;

    typedef struct {
        in_item_t  it;
        bit        typed;
        out_item_t res;
    } row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_item_t in_item;
    logic out_valid;
    logic out_stall;
    out_item_t out_item;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    recursive_coordinate_bisection dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    longint pt_x[NPTS];
    longint pt_y[NPTS];
    int     sorted_idx[NPTS];
    int     cell_of[NPTS];
    int     n_loaded;
    bit     is_split;
    int     cols_reg, rows_reg, tol_reg;
    int     seg_s[NSTK], seg_n[NSTK], seg_px[NSTK], seg_py[NSTK], seg_dx[NSTK], seg_dy[NSTK];
    int     seg_top;

    out_item_t pending_results[$];
    int send_idle_pct, recv_stall_pct, recv_hold;
    int n_errors;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #100ms;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int side_clamp(int v);
        if (v == 0)
            return 1;
        if (v > NSIDE)
            return NSIDE;
        return v;
    endfunction

    function automatic int tol_order(longint a, longint b);
        if (a + longint'(tol_reg) < b)
            return -1;
        if (a > b + longint'(tol_reg))
            return 1;
        return 0;
    endfunction

    function automatic int point_order(int a, int b, bit xfirst);
        int c;
        if (xfirst)
        begin
            c = tol_order(pt_x[a], pt_x[b]);
            if (c == 0)
                c = tol_order(pt_y[a], pt_y[b]);
        end
        else
        begin
            c = tol_order(pt_y[a], pt_y[b]);
            if (c == 0)
                c = tol_order(pt_x[a], pt_x[b]);
        end
        return c;
    endfunction

    function automatic void sort_segment(int s, int n, bit xfirst);
        int key, j;
        for (int i = 1; i < n; i++)
        begin
            key = sorted_idx[s + i];
            j = i;
            while (j > 0 && point_order(sorted_idx[s + j - 1], key, xfirst) > 0)
            begin
                sorted_idx[s + j] = sorted_idx[s + j - 1];
                j--;
            end
            sorted_idx[s + j] = key;
        end
    endfunction

    function automatic void push_segment(int s, int n, int px, int py, int dx, int dy);
        if (n == 0 || seg_top >= NSTK)
            return;
        seg_s[seg_top] = s;
        seg_n[seg_top] = n;
        seg_px[seg_top] = px;
        seg_py[seg_top] = py;
        seg_dx[seg_top] = dx;
        seg_dy[seg_top] = dy;
        seg_top++;
    endfunction

    function automatic void bisect_points();
        int cols, rows, s, n, px, py, dx, dy, p0, p1, n0, leaf_cell;
        cols = side_clamp(cols_reg);
        rows = side_clamp(rows_reg);
        for (int i = 0; i < n_loaded; i++)
        begin
            sorted_idx[i] = i;
            cell_of[i] = 0;
        end
        seg_top = 0;
        push_segment(0, n_loaded, 0, 0, cols, rows);
        while (seg_top > 0)
        begin
            seg_top--;
            s = seg_s[seg_top]; n = seg_n[seg_top];
            px = seg_px[seg_top]; py = seg_py[seg_top];
            dx = seg_dx[seg_top]; dy = seg_dy[seg_top];
            if (dx <= 1 && dy <= 1)
            begin
                leaf_cell = (py * cols + px) & 16'hFFFF;
                for (int i = 0; i < n; i++)
                    cell_of[sorted_idx[s + i]] = leaf_cell;
            end
            else if (dx >= dy)
            begin
                p0 = dx / 2; p1 = dx - p0;
                n0 = (p0 * n) / dx;
                sort_segment(s, n, 1'b1);
                push_segment(s + n0, n - n0, px + p0, py, p1, dy);
                push_segment(s, n0, px, py, p0, dy);
            end
            else
            begin
                p0 = dy / 2; p1 = dy - p0;
                n0 = (p0 * n) / dy;
                sort_segment(s, n, 1'b0);
                push_segment(s + n0, n - n0, px, py + p0, dx, p1);
                push_segment(s, n0, px, py, dx, p0);
            end
        end
        is_split = 1'b1;
    endfunction

    function automatic out_item_t predict_result(in_item_t it);
        out_item_t r;
        r.status = STS_OK;
        r.partition = '0;
        case (action_t'(it.action))
            ACT_CLEAR:
            begin
                n_loaded = 0;
                is_split = 1'b0;
            end
            ACT_APPEND:
            begin
                if (n_loaded >= NPTS)
                    r.status = STS_FULL;
                else
                begin
                    pt_x[n_loaded] = longint'(it.x_coord);
                    pt_y[n_loaded] = longint'(it.y_coord);
                    n_loaded++;
                    is_split = 1'b0;
                end
            end
            ACT_RUN:
                bisect_points();
            default:
            begin
                if (is_split && int'(it.point_index) < n_loaded)
                    r.partition = cell_of[it.point_index][CELL_W-1:0];
                else
                    r.status = STS_BAD;
            end
        endcase
        r.point_count = n_loaded[COUNT_W-1:0];
        return r;
    endfunction

    // sender: offer at the edge, check stall at the falling edge, accepted at the next edge
    task automatic send_item(in_item_t it, bit typed, out_item_t res);
        bit taken;
        out_item_t p;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        p = predict_result(it);
        pending_results.push_back(typed ? res : p);
    endtask

    task automatic send_plain(in_item_t it);
        send_item(it, 1'b0, '0);
    endtask

    function automatic in_item_t make_item(action_t a, logic [31:0] x, logic [31:0] y, int idx);
        in_item_t it;
        it.action = a;
        it.x_coord = x;
        it.y_coord = y;
        it.point_index = idx[INDEX_W-1:0];
        return it;
    endfunction

    task automatic drain();
        if (send_idle_pct >= 0)
            in_valid <= 1'b0;
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, int value);
        bit taken;
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        cfg_valid <= 1'b0;
        case (idx)
            REG_COLUMNS:   cols_reg = value & 9'h1FF;
            REG_ROWS:      rows_reg = value & 9'h1FF;
            default:       tol_reg = value & 16'hFFFF;
        endcase
    endtask

    // receiver: sample at the falling edge, result taken at the next edge
    initial
    begin
        bit take;
        out_item_t got, want;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            take = out_valid && !out_stall;
            got = out_item;
            @(posedge clk);
            if (take)
            begin
                if (pending_results.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("unexpected result item: %p", got);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status || got.partition !== want.partition
                        || got.point_count !== want.point_count)
                    begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("mismatch: expected %p, got %p", want, got);
                    end
                end
            end
            if (recv_hold > 0)
            begin
                recv_hold--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct;
        end
    end

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return 32'(int'($urandom_range(0, 6)) - 3) <<< 2;
            default:
                case ($urandom_range(3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'(int'($urandom_range(0, 40)) - 20);
                    default: return $urandom;
                endcase
        endcase
    endfunction

    // one well-formed set: clear, load, run, read back; a little noise mixed in
    task automatic run_point_set(int n);
        int mode;
        in_item_t it;
        mode = $urandom_range(2);
        send_plain(make_item(ACT_CLEAR, $urandom, $urandom, $urandom));
        for (int i = 0; i < n; i++)
            send_plain(make_item(ACT_APPEND, rand_coord(mode), rand_coord(mode), $urandom));
        if ($urandom_range(9) == 0)
            send_plain(make_item(ACT_READ, 0, 0, $urandom_range(NPTS - 1)));
        send_plain(make_item(ACT_RUN, $urandom, $urandom, $urandom));
        for (int i = 0; i < n + 2; i++)
        begin
            if ($urandom_range(9) == 0)
            begin
                it.action = 2'($urandom);
                it.x_coord = $urandom;
                it.y_coord = $urandom;
                it.point_index = INDEX_W'($urandom);
                if (action_t'(it.action) == ACT_RUN)
                    it.action = ACT_READ;
                send_plain(it);
            end
            else
                send_plain(make_item(ACT_READ, $urandom, $urandom,
                    $urandom_range(n + 1)));
        end
    endtask

    task automatic random_grid();
        int c, r, t;
        case ($urandom_range(5))
            0: c = 0;
            1: c = 511;
            2: c = NSIDE;
            default: c = $urandom_range(1, 12);
        endcase
        case ($urandom_range(5))
            0: r = 0;
            1: r = 300;
            2: r = NSIDE;
            default: r = $urandom_range(1, 12);
        endcase
        case ($urandom_range(3))
            0: t = 0;
            1: t = 65535;
            default: t = $urandom_range(0, 8);
        endcase
        write_reg(REG_COLUMNS, c);
        write_reg(REG_ROWS, r);
        write_reg(REG_TOLERANCE, t);
    endtask

    row_t directed[$];

    function automatic row_t typed_row(in_item_t it, status_t s, int part, int cnt);
        row_t r;
        r.it = it;
        r.typed = 1'b1;
        r.res.status = s;
        r.res.partition = part[CELL_W-1:0];
        r.res.point_count = cnt[COUNT_W-1:0];
        return r;
    endfunction

    initial
    begin
        int idle_mix[4][2];
        n_errors = 0;
        n_loaded = 0;
        is_split = 1'b0;
        cols_reg = 1;
        rows_reg = 1;
        tol_reg = 1;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        recv_hold = 0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_COLUMNS;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset the grid is 1x1, so every point lands in cell 0
        directed.push_back(typed_row(make_item(ACT_READ, 0, 0, 0), STS_BAD, 0, 0));
        directed.push_back(typed_row(make_item(ACT_RUN, 0, 0, 0), STS_OK, 0, 0));
        directed.push_back(typed_row(make_item(ACT_READ, 0, 0, 0), STS_BAD, 0, 0));
        directed.push_back(typed_row(make_item(ACT_APPEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0),
            STS_OK, 0, 1));
        directed.push_back(typed_row(make_item(ACT_APPEND, 32'h8000_0000, 32'h8000_0000, 1023),
            STS_OK, 0, 2));
        directed.push_back(typed_row(make_item(ACT_APPEND, 0, 0, 0), STS_OK, 0, 3));
        directed.push_back(typed_row(make_item(ACT_APPEND, 32'hFFFF_FFFF, 1, 0), STS_OK, 0, 4));
        directed.push_back(typed_row(make_item(ACT_READ, 0, 0, 0), STS_BAD, 0, 4));
        directed.push_back(typed_row(make_item(ACT_RUN, 0, 0, 0), STS_OK, 0, 4));
        directed.push_back(typed_row(make_item(ACT_READ, 0, 0, 0), STS_OK, 0, 4));
        directed.push_back(typed_row(make_item(ACT_READ, 0, 0, 3), STS_OK, 0, 4));
        directed.push_back(typed_row(make_item(ACT_READ, 0, 0, 4), STS_BAD, 0, 4));
        directed.push_back(typed_row(make_item(ACT_READ, 0, 0, 1023), STS_BAD, 0, 4));
        directed.push_back(typed_row(make_item(ACT_CLEAR, 0, 0, 0), STS_OK, 0, 0));
        directed.push_back(typed_row(make_item(ACT_READ, 0, 0, 0), STS_BAD, 0, 0));
        foreach (directed[i])
            send_item(directed[i].it, directed[i].typed, directed[i].res);

        // ties within tolerance, extremes of the grid; checked by the predictor
        write_reg(REG_COLUMNS, 3);
        write_reg(REG_ROWS, 2);
        write_reg(REG_TOLERANCE, 4);
        send_plain(make_item(ACT_APPEND, 10, 5, 0));
        send_plain(make_item(ACT_APPEND, 12, 1, 0));
        send_plain(make_item(ACT_APPEND, 13, 9, 0));
        send_plain(make_item(ACT_APPEND, -20, 9, 0));
        send_plain(make_item(ACT_APPEND, 32'h7FFF_FFFF, 32'h8000_0000, 0));
        send_plain(make_item(ACT_APPEND, 10, 5, 0));
        send_plain(make_item(ACT_RUN, 0, 0, 0));
        for (int i = 0; i < 6; i++)
            send_plain(make_item(ACT_READ, 0, 0, i));
        write_reg(REG_COLUMNS, 0);
        write_reg(REG_ROWS, 511);
        write_reg(REG_TOLERANCE, 65535);
        send_plain(make_item(ACT_RUN, 0, 0, 0));
        send_plain(make_item(ACT_READ, 0, 0, 4));
        send_plain(make_item(ACT_CLEAR, 0, 0, 0));

        idle_mix = '{'{0, 0}, '{47, 0}, '{0, 47}, '{17, 17}};
        for (int m = 0; m < 4; m++)
        begin
            drain();
            send_idle_pct = idle_mix[m][0];
            recv_stall_pct = idle_mix[m][1];
            for (int k = 0; k < 3; k++)
            begin
                random_grid();
                if (m == 2 && k == 0)
                    recv_hold = 300;
                run_point_set(($urandom_range(7) == 0) ? $urandom_range(30, 60)
                    : $urandom_range(1, 14));
            end
        end

        drain();
        if (n_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
